>>> design/source_tokenizer_assert.svh
// Assertion macros shared by the source tokenizer modules.
// Needs nothing else; include it by its bare file name.
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define STK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("source_tokenizer: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define STK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("source_tokenizer: next-cycle check failed");

`endif

>>> design/srctok_pkg.sv
// Shared types, character codes and classification helpers of the source tokenizer.
// Depends on nothing; every design module imports it.
package srctok_pkg;

    localparam int TEXT_W = 8;
    localparam int LEN_W  = 16;
    localparam int POS_W  = 16;
    localparam int CFG_W  = 16;

    // Configuration register indexes
    localparam logic [0:0] CFG_START_LINE   = 1'b0;
    localparam logic [0:0] CFG_START_COLUMN = 1'b1;

    // Result kinds; K_VALUE doubles as "no held token" in the front end
    typedef enum logic [3:0] {
        K_VALUE  = 4'd0,
        K_ERROR  = 4'd1,
        K_EOF    = 4'd2,
        K_WORD   = 4'd3,
        K_INT    = 4'd4,
        K_FLOAT  = 4'd5,
        K_ASSIGN = 4'd6,
        K_SEMI   = 4'd7,
        K_LPAREN = 4'd8,
        K_RPAREN = 4'd9,
        K_LBRACE = 4'd10,
        K_RBRACE = 4'd11,
        K_MUL    = 4'd12,
        K_COLON  = 4'd13,
        K_ARROW  = 4'd14
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE = 2'd0,
        E_DASH = 2'd1,
        E_BAD  = 2'd2
    } t_err;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        t_kind              kind;
        logic [TEXT_W-1:0]  ch;
        logic [LEN_W-1:0]   len;
        logic [POS_W-1:0]   line;
        logic [POS_W-1:0]   col;
        t_err               err;
    } t_result;

    // Up to two results caused by one input item
    typedef struct packed {
        logic              two;
        t_result [1:0]     res;
    } t_bundle;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        case (c)
            CH_EQ:     punct_kind = K_ASSIGN;
            CH_SEMI:   punct_kind = K_SEMI;
            CH_LPAREN: punct_kind = K_LPAREN;
            CH_RPAREN: punct_kind = K_RPAREN;
            CH_LBRACE: punct_kind = K_LBRACE;
            CH_RBRACE: punct_kind = K_RBRACE;
            CH_STAR:   punct_kind = K_MUL;
            CH_COLON:  punct_kind = K_COLON;
            default:   punct_kind = K_VALUE;
        endcase
    endfunction

    function automatic t_result make_result(input t_kind k, input logic [TEXT_W-1:0] ch,
                                            input logic [LEN_W-1:0] len,
                                            input logic [POS_W-1:0] line,
                                            input logic [POS_W-1:0] col, input t_err e);
        t_result r;
        r.kind = k;
        r.ch   = ch;
        r.len  = len;
        r.line = line;
        r.col  = col;
        r.err  = e;
        make_result = r;
    endfunction

endpackage

>>> design/srctok_front.sv
// Front end of the source tokenizer: accepts bytes, tracks position and scan mode,
// and builds the bundle of results for each item. Depends on srctok_pkg.
`include "source_tokenizer_assert.svh"

module srctok_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [srctok_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [srctok_pkg::TEXT_W-1:0] i_text_byte,
    input  logic                          i_end_of_text,
    input  logic                          i_full,
    output logic                          o_push,
    output srctok_pkg::t_bundle           o_bundle
);
    import srctok_pkg::*;

    // Position counters are never narrower than the start registers
    localparam int CW = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
    localparam logic [CW-1:0] COORD_MAX = CW'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_INT, M_FLOAT, M_MINUS, M_SLASH, M_COMMENT, M_DONE, M_ERR1, M_ERR2
    } t_mode;

    t_mode            r_mode, n_mode;
    t_kind            r_pending, n_pending;
    logic [CW-1:0]    r_line, n_line, r_col, n_col;
    logic             r_seen, n_seen;
    logic [LEN_W-1:0] r_count, n_count;
    logic [POS_W-1:0] r_held_line, n_held_line, r_held_col, n_held_col;
    logic [CFG_W-1:0] r_start_line, r_start_col;

    logic [CW-1:0]    eff_line, eff_col, pos_line, pos_col;
    logic [POS_W-1:0] eff_line16, eff_col16, pos_line16, pos_col16;
    logic [1:0]       cnt;
    logic             idle_path, value_path, fresh, accept;
    logic [LEN_W-1:0] count_base;
    t_kind            pk, scan_kind;
    t_result [1:0]    res_slot;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v >= COORD_MAX) ? COORD_MAX : v + 1'b1;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (cnt != 2'd0);
    assign o_bundle.two = cnt[1];
    assign o_bundle.res = res_slot;

    // Position of the current byte and of the end mark
    always_comb begin
        eff_line = r_seen ? r_line : CW'(r_start_line);
        eff_col  = r_seen ? r_col  : CW'(r_start_col);
        if (!r_seen) begin
            pos_line = eff_line;
            pos_col  = eff_col;
        end else if (i_text_byte == CH_LF) begin
            pos_line = sat_inc(r_line);
            pos_col  = CW'(1);
        end else begin
            pos_line = r_line;
            pos_col  = sat_inc(r_col);
        end
    end

    assign eff_line16 = eff_line[POS_W-1:0];
    assign eff_col16  = eff_col[POS_W-1:0];
    assign pos_line16 = pos_line[POS_W-1:0];
    assign pos_col16  = pos_col[POS_W-1:0];
    assign pk         = punct_kind(i_text_byte);
    assign scan_kind  = (r_mode == M_WORD) ? K_WORD : ((r_mode == M_INT) ? K_INT : K_FLOAT);

    // Scan step: next state and the results of this item
    always_comb begin
        n_mode      = r_mode;
        n_pending   = r_pending;
        n_line      = r_line;
        n_col       = r_col;
        n_seen      = r_seen;
        n_count     = r_count;
        n_held_line = r_held_line;
        n_held_col  = r_held_col;
        cnt         = 2'd0;
        res_slot    = '0;
        idle_path   = 1'b0;
        value_path  = 1'b0;
        fresh       = 1'b0;
        count_base  = r_count;

        if (r_mode == M_ERR1 || r_mode == M_ERR2) begin
            // repeat the held error
            res_slot[0] = make_result(K_ERROR, '0, '0, r_held_line, r_held_col,
                                      (r_mode == M_ERR1) ? E_DASH : E_BAD);
            cnt = 2'd1;
        end else if (i_end_of_text) begin
            n_line = eff_line;
            n_col  = eff_col;
            case (r_mode)
                M_MINUS: begin
                    n_mode      = M_ERR1;
                    res_slot[0] = make_result(K_ERROR, '0, '0, r_held_line, r_held_col,
                                              E_DASH);
                    cnt = 2'd1;
                end
                M_SLASH: begin
                    n_mode      = M_ERR2;
                    res_slot[0] = make_result(K_ERROR, '0, '0, r_held_line, r_held_col,
                                              E_BAD);
                    cnt = 2'd1;
                end
                default: begin
                    // flush the open or held token, then close the text
                    if (r_mode == M_WORD || r_mode == M_INT || r_mode == M_FLOAT) begin
                        res_slot[0] = make_result(scan_kind, '0, r_count, eff_line16,
                                                  eff_col16, E_NONE);
                        cnt = 2'd1;
                    end else if (r_pending != K_VALUE) begin
                        res_slot[0] = make_result(r_pending, '0, '0, eff_line16, eff_col16,
                                                  E_NONE);
                        cnt = 2'd1;
                    end
                    res_slot[cnt[0]] = make_result(K_EOF, '0, '0, eff_line16, eff_col16,
                                                   E_NONE);
                    cnt       = cnt + 2'd1;
                    n_pending = K_VALUE;
                    n_mode    = M_DONE;
                end
            endcase
        end else if (r_mode != M_DONE) begin
            n_line = pos_line;
            n_col  = pos_col;
            n_seen = 1'b1;
            case (r_mode)
                M_WORD: begin
                    if (is_alpha(i_text_byte) || is_digit(i_text_byte) ||
                        i_text_byte == CH_UNDER) begin
                        value_path = 1'b1;
                    end else begin
                        res_slot[0] = make_result(K_WORD, '0, r_count, pos_line16,
                                                  pos_col16, E_NONE);
                        cnt       = 2'd1;
                        n_mode    = M_IDLE;
                        idle_path = 1'b1;
                    end
                end
                M_INT: begin
                    if (is_digit(i_text_byte)) begin
                        value_path = 1'b1;
                    end else if (i_text_byte == CH_DOT) begin
                        n_mode     = M_FLOAT;
                        value_path = 1'b1;
                    end else begin
                        res_slot[0] = make_result(K_INT, '0, r_count, pos_line16,
                                                  pos_col16, E_NONE);
                        cnt       = 2'd1;
                        n_mode    = M_IDLE;
                        idle_path = 1'b1;
                    end
                end
                M_FLOAT: begin
                    if (is_digit(i_text_byte)) begin
                        value_path = 1'b1;
                    end else begin
                        res_slot[0] = make_result(K_FLOAT, '0, r_count, pos_line16,
                                                  pos_col16, E_NONE);
                        cnt       = 2'd1;
                        n_mode    = M_IDLE;
                        idle_path = 1'b1;
                    end
                end
                M_MINUS: begin
                    if (i_text_byte == CH_GT) begin
                        n_pending = K_ARROW;
                        n_mode    = M_IDLE;
                    end else begin
                        n_mode      = M_ERR1;
                        res_slot[0] = make_result(K_ERROR, '0, '0, r_held_line, r_held_col,
                                                  E_DASH);
                        cnt = 2'd1;
                    end
                end
                M_SLASH: begin
                    if (i_text_byte == CH_SLASH) begin
                        n_mode = M_COMMENT;
                    end else begin
                        n_mode      = M_ERR2;
                        res_slot[0] = make_result(K_ERROR, '0, '0, r_held_line, r_held_col,
                                                  E_BAD);
                        cnt = 2'd1;
                    end
                end
                M_COMMENT: begin
                    if (i_text_byte == CH_LF) begin
                        n_mode = M_IDLE;
                    end
                end
                default: begin
                    // release a held punctuation token at this byte's position
                    if (r_pending != K_VALUE) begin
                        res_slot[0] = make_result(r_pending, '0, '0, pos_line16, pos_col16,
                                                  E_NONE);
                        cnt       = 2'd1;
                        n_pending = K_VALUE;
                    end
                    idle_path = 1'b1;
                end
            endcase

            // this byte starts something new
            if (idle_path) begin
                if (is_space(i_text_byte)) begin
                    n_mode = M_IDLE;
                end else if (pk != K_VALUE) begin
                    n_pending = pk;
                end else if (i_text_byte == CH_DASH || i_text_byte == CH_SLASH) begin
                    n_mode      = (i_text_byte == CH_DASH) ? M_MINUS : M_SLASH;
                    n_held_line = pos_line16;
                    n_held_col  = pos_col16;
                end else if (is_alpha(i_text_byte)) begin
                    n_mode     = M_WORD;
                    fresh      = 1'b1;
                    value_path = 1'b1;
                end else if (is_digit(i_text_byte)) begin
                    n_mode     = M_INT;
                    fresh      = 1'b1;
                    value_path = 1'b1;
                end else begin
                    n_mode           = M_ERR2;
                    n_held_line      = pos_line16;
                    n_held_col       = pos_col16;
                    res_slot[cnt[0]] = make_result(K_ERROR, '0, '0, pos_line16, pos_col16,
                                                   E_BAD);
                    cnt = cnt + 2'd1;
                end
            end

            // count and give out one value character
            if (value_path) begin
                count_base       = fresh ? '0 : r_count;
                n_count          = (count_base == LEN_MAX) ? count_base : count_base + 1'b1;
                res_slot[cnt[0]] = make_result(K_VALUE, i_text_byte, '0, pos_line16,
                                               pos_col16, E_NONE);
                cnt = cnt + 2'd1;
            end
        end
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_IDLE;
            r_pending    <= K_VALUE;
            r_line       <= CW'(1);
            r_col        <= CW'(1);
            r_seen       <= 1'b0;
            r_count      <= '0;
            r_held_line  <= '0;
            r_held_col   <= '0;
            r_start_line <= CFG_W'(1);
            r_start_col  <= CFG_W'(1);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_LINE:   r_start_line <= i_cfg_data;
                    CFG_START_COLUMN: r_start_col  <= i_cfg_data;
                    default:          r_start_line <= r_start_line;
                endcase
            end
            if (accept) begin
                r_mode      <= n_mode;
                r_pending   <= n_pending;
                r_line      <= n_line;
                r_col       <= n_col;
                r_seen      <= n_seen;
                r_count     <= n_count;
                r_held_line <= n_held_line;
                r_held_col  <= n_held_col;
            end
        end
    end

    // Errors hold until reset
    `STK_ASSERT_NEXT(a_dash_err_sticky, i_clk, i_rst_n, r_mode == M_ERR1, r_mode == M_ERR1)
    `STK_ASSERT_NEXT(a_bad_err_sticky, i_clk, i_rst_n, r_mode == M_ERR2, r_mode == M_ERR2)

endmodule

>>> design/srctok_fifo.sv
// Short result queue between the tokenizer front end and back end.
// Holds one bundle per entry; depends on srctok_pkg.
module srctok_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  srctok_pkg::t_bundle i_data,
    output logic                o_full,
    input  logic                i_pop,
    output srctok_pkg::t_bundle o_head,
    output logic                o_empty
);
    import srctok_pkg::*;

    t_bundle         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_fill;

    assign o_full  = (r_fill == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rp];

    // Store incoming bundles
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> design/srctok_back.sv
// Back end of the source tokenizer: splits queued bundles into single results
// and drives the output register. Depends on srctok_pkg.
`include "source_tokenizer_assert.svh"

module srctok_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srctok_pkg::t_bundle           i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [3:0]                    o_result_kind,
    output logic [srctok_pkg::TEXT_W-1:0] o_value_char,
    output logic [srctok_pkg::LEN_W-1:0]  o_token_length,
    output logic [srctok_pkg::POS_W-1:0]  o_line,
    output logic [srctok_pkg::POS_W-1:0]  o_column,
    output logic [1:0]                    o_error_code,
    output logic                          o_last
);
    import srctok_pkg::*;

    t_result r_out;
    logic    r_valid, r_last, r_sel;
    logic    load, head_last;

    assign head_last = r_sel || !i_head.two;
    assign load      = !i_empty && (!r_valid || i_ready);
    assign o_pop     = load && head_last;

    // Load the next result whenever one waits and the output register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sel   <= !head_last;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out  <= i_head.res[r_sel];
            r_last <= head_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_kind  = r_out.kind;
    assign o_value_char   = r_out.ch;
    assign o_token_length = r_out.len;
    assign o_line         = r_out.line;
    assign o_column       = r_out.col;
    assign o_error_code   = r_out.err;
    assign o_last         = r_last;

    // Second half of a bundle waits at the queue head
    `STK_ASSERT_SAME(a_second_waits, i_clk, i_rst_n, r_sel, !i_empty)
    // A non-final result is followed at once by the next one
    `STK_ASSERT_NEXT(a_pair_back_to_back, i_clk, i_rst_n, o_valid && i_ready && !o_last, o_valid)

endmodule

>>> design/source_tokenizer.sv
// Source tokenizer top level: front end, result queue and back end.
// Depends on srctok_pkg, srctok_front, srctok_fifo and srctok_back.
//
// Input channel: one text byte or an end mark per item (i_valid / o_ready).
// Output channel: one result per transfer (o_valid / i_ready); o_last flags the
// final result an input item caused. Items that cause no result (blanks,
// comment text, held punctuation) produce nothing on the output.
// Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_index
// (0 start line, 1 start column) in the same cycle; write only while idle.
// Results of an accepted item are written to the queue at the accepting edge and
// move on into the output register as soon as it is free.
// Throughput: one item per cycle while items give at most one result each and the
// receiver keeps i_ready high; the output port moves one result per cycle, so a run
// of items with two results drains slower than it is taken.
// Stalls: a four-entry queue decouples the sides; o_ready drops while the queue
// is full, which happens when the receiver holds i_ready low or when two-result
// items arrive faster than the output drains them.
// Reset: scan state cleared, start line and column set to 1, queue emptied.
module source_tokenizer #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [srctok_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [srctok_pkg::TEXT_W-1:0] i_text_byte,
    input  logic                          i_end_of_text,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [3:0]                    o_result_kind,
    output logic [srctok_pkg::TEXT_W-1:0] o_value_char,
    output logic [srctok_pkg::LEN_W-1:0]  o_token_length,
    output logic [srctok_pkg::POS_W-1:0]  o_line,
    output logic [srctok_pkg::POS_W-1:0]  o_column,
    output logic [1:0]                    o_error_code,
    output logic                          o_last
);
    import srctok_pkg::*;

    t_bundle push_data, head;
    logic    push, full, pop, empty;

    srctok_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_text_byte  (i_text_byte),
        .i_end_of_text(i_end_of_text),
        .i_full       (full),
        .o_push       (push),
        .o_bundle     (push_data)
    );

    srctok_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_data),
        .o_full (full),
        .i_pop  (pop),
        .o_head (head),
        .o_empty(empty)
    );

    srctok_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_value_char  (o_value_char),
        .o_token_length(o_token_length),
        .o_line        (o_line),
        .o_column      (o_column),
        .o_error_code  (o_error_code),
        .o_last        (o_last)
    );

endmodule

>>> bench/tok_check_pkg.sv
// Scoreboard for the source tokenizer bench: a byte-level scan predictor and the result check.
// Depends on srctok_pkg for result kinds, error codes, character codes and register indexes.
`timescale 1ns / 100ps
package tok_check_pkg;
    import srctok_pkg::*;

    // Scanner states of the predictor
    typedef enum logic [3:0] {
        SC_IDLE,
        SC_WORD,
        SC_INT,
        SC_FLOAT,
        SC_DASH,
        SC_SLASH,
        SC_COMMENT,
        SC_DONE,
        SC_ERR_DASH,
        SC_ERR_BAD
    } scan_t;

    typedef struct {
        t_kind       kind;
        logic [7:0]  ch;
        logic [15:0] len;
        logic [15:0] line;
        logic [15:0] col;
        t_err        err;
        logic        last;
    } token_result_t;

    class token_scoreboard;
        logic [15:0]   first_line;
        logic [15:0]   first_col;
        scan_t         mode;
        t_kind         held_kind;
        logic [15:0]   pos_line;
        logic [15:0]   pos_col;
        logic          seen;
        logic [15:0]   run_len;
        logic [15:0]   mark_line;
        logic [15:0]   mark_col;
        token_result_t due[$];
        int            step_count;
        int            errors;

        function new();
            first_line = 16'd1;
            first_col  = 16'd1;
            mode       = SC_IDLE;
            held_kind  = K_VALUE;
            pos_line   = 16'd1;
            pos_col    = 16'd1;
            seen       = 1'b0;
            run_len    = 16'd0;
            mark_line  = 16'd0;
            mark_col   = 16'd0;
            step_count = 0;
            errors     = 0;
        endfunction

        static function logic is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        static function logic is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        static function t_kind punct_of(logic [7:0] c);
            case (c)
                CH_EQ:     return K_ASSIGN;
                CH_SEMI:   return K_SEMI;
                CH_LPAREN: return K_LPAREN;
                CH_RPAREN: return K_RPAREN;
                CH_LBRACE: return K_LBRACE;
                CH_RBRACE: return K_RBRACE;
                CH_STAR:   return K_MUL;
                CH_COLON:  return K_COLON;
                default:   return K_VALUE;
            endcase
        endfunction

        // Saturating position step
        static function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function void set_start(logic [0:0] idx, logic [15:0] val);
            if (idx == CFG_START_LINE) begin
                first_line = val;
            end else begin
                first_col = val;
            end
        endfunction

        function int outstanding();
            return due.size();
        endfunction

        // Queue one expected result; the newest one of an item carries last
        function void push(t_kind k, logic [7:0] ch, logic [15:0] len, logic [15:0] ln,
                           logic [15:0] cl, t_err e);
            token_result_t r;
            if (step_count > 0) begin
                due[due.size() - 1].last = 1'b0;
            end
            r.kind = k;
            r.ch   = ch;
            r.len  = len;
            r.line = ln;
            r.col  = cl;
            r.err  = e;
            r.last = 1'b1;
            due.insert(due.size(), r);
            step_count++;
        endfunction

        // Advance the scanner by one accepted item and queue what it yields
        function void note_input(logic [7:0] c, logic eot);
            logic  grab;
            logic  fresh;
            t_kind pk;
            step_count = 0;
            grab  = 1'b0;
            fresh = 1'b0;

            // Hold the error until reset
            if (mode == SC_ERR_DASH || mode == SC_ERR_BAD) begin
                push(K_ERROR, 0, 0, mark_line, mark_col, (mode == SC_ERR_DASH) ? E_DASH : E_BAD);
                return;
            end
            if (!seen) begin
                pos_line = first_line;
                pos_col  = first_col;
            end

            // End mark: flush the open or held token, then eof; a pending dash or slash gives its error instead
            if (eot) begin
                case (mode)
                    SC_WORD:  push(K_WORD, 0, run_len, pos_line, pos_col, E_NONE);
                    SC_INT:   push(K_INT, 0, run_len, pos_line, pos_col, E_NONE);
                    SC_FLOAT: push(K_FLOAT, 0, run_len, pos_line, pos_col, E_NONE);
                    SC_DASH, SC_SLASH: begin
                        mode = (mode == SC_DASH) ? SC_ERR_DASH : SC_ERR_BAD;
                        push(K_ERROR, 0, 0, mark_line, mark_col,
                             (mode == SC_ERR_DASH) ? E_DASH : E_BAD);
                        return;
                    end
                    default: begin
                        if (held_kind != K_VALUE) begin
                            push(held_kind, 0, 0, pos_line, pos_col, E_NONE);
                        end
                    end
                endcase
                held_kind = K_VALUE;
                mode      = SC_DONE;
                push(K_EOF, 0, 0, pos_line, pos_col, E_NONE);
                return;
            end
            if (mode == SC_DONE) begin
                return;
            end

            // Track the position of this byte
            if (!seen) begin
                seen = 1'b1;
            end else if (c == CH_LF) begin
                pos_line = bump(pos_line);
                pos_col  = 16'd1;
            end else begin
                pos_col = bump(pos_col);
            end

            case (mode)
                SC_WORD: begin
                    if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
                        grab = 1'b1;
                    end else begin
                        push(K_WORD, 0, run_len, pos_line, pos_col, E_NONE);
                        mode  = SC_IDLE;
                        fresh = 1'b1;
                    end
                end
                SC_INT: begin
                    if (is_digit(c)) begin
                        grab = 1'b1;
                    end else if (c == CH_DOT) begin
                        mode = SC_FLOAT;
                        grab = 1'b1;
                    end else begin
                        push(K_INT, 0, run_len, pos_line, pos_col, E_NONE);
                        mode  = SC_IDLE;
                        fresh = 1'b1;
                    end
                end
                SC_FLOAT: begin
                    if (is_digit(c)) begin
                        grab = 1'b1;
                    end else begin
                        push(K_FLOAT, 0, run_len, pos_line, pos_col, E_NONE);
                        mode  = SC_IDLE;
                        fresh = 1'b1;
                    end
                end
                SC_DASH: begin
                    if (c == CH_GT) begin
                        held_kind = K_ARROW;
                        mode      = SC_IDLE;
                    end else begin
                        mode = SC_ERR_DASH;
                        push(K_ERROR, 0, 0, mark_line, mark_col, E_DASH);
                    end
                    return;
                end
                SC_SLASH: begin
                    if (c == CH_SLASH) begin
                        mode = SC_COMMENT;
                    end else begin
                        mode = SC_ERR_BAD;
                        push(K_ERROR, 0, 0, mark_line, mark_col, E_BAD);
                    end
                    return;
                end
                SC_COMMENT: begin
                    if (c == CH_LF) begin
                        mode = SC_IDLE;
                    end
                    return;
                end
                default: begin
                    if (held_kind != K_VALUE) begin
                        push(held_kind, 0, 0, pos_line, pos_col, E_NONE);
                        held_kind = K_VALUE;
                    end
                    fresh = 1'b1;
                end
            endcase

            // Byte starts something new
            if (fresh) begin
                pk = punct_of(c);
                if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
                    return;
                end
                if (pk != K_VALUE) begin
                    held_kind = pk;
                    return;
                end
                if (c == CH_DASH || c == CH_SLASH) begin
                    mode      = (c == CH_DASH) ? SC_DASH : SC_SLASH;
                    mark_line = pos_line;
                    mark_col  = pos_col;
                    return;
                end
                if (is_letter(c) || is_digit(c)) begin
                    mode    = is_letter(c) ? SC_WORD : SC_INT;
                    run_len = 16'd0;
                    grab    = 1'b1;
                end else begin
                    mode      = SC_ERR_BAD;
                    mark_line = pos_line;
                    mark_col  = pos_col;
                    push(K_ERROR, 0, 0, mark_line, mark_col, E_BAD);
                    return;
                end
            end

            if (grab) begin
                if (run_len != 16'hFFFF) begin
                    run_len++;
                end
                push(K_VALUE, c, 0, pos_line, pos_col, E_NONE);
            end
        endfunction

        function void match(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [3:0] kind, logic [7:0] ch, logic [15:0] len,
                                   logic [15:0] ln, logic [15:0] cl, logic [1:0] err,
                                   logic last);
            token_result_t w;
            if (due.size() == 0) begin
                $error("result_kind: expected no result, got %0d", kind);
                errors++;
                return;
            end
            w = due.pop_front();
            match("result_kind", w.kind, kind);
            match("value_char", w.ch, ch);
            match("token_length", w.len, len);
            match("line", w.line, ln);
            match("column", w.col, cl);
            match("error_code", w.err, err);
            match("last", w.last, last);
        endfunction
    endclass

endpackage

>>> bench/tb_top.sv
// Top of the source tokenizer bench: clock, reset, stimulus, receiver and final verdict.
// Depends on srctok_pkg, tok_check_pkg and the source_tokenizer design.
`timescale 1ns / 100ps
module tb_top;
    import srctok_pkg::*;
    import tok_check_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 12;
    localparam int RANDOM_PER_PHASE = 260;
    localparam int PRESSURE_CYCLES  = 300;
    localparam int SETTLE_CYCLES    = 12;
    // Bound on the run, set above the slowest run (stalled phases, two results per item)
    localparam int CYCLE_LIMIT      = 1000000;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [0:0]          i_cfg_index   = CFG_START_LINE;
    logic [CFG_W-1:0]    i_cfg_data    = '0;
    logic                i_valid       = 1'b0;
    logic [TEXT_W-1:0]   i_text_byte   = '0;
    logic                i_end_of_text = 1'b0;
    logic                i_ready       = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [3:0]          o_result_kind;
    logic [TEXT_W-1:0]   o_value_char;
    logic [LEN_W-1:0]    o_token_length;
    logic [POS_W-1:0]    o_line;
    logic [POS_W-1:0]    o_column;
    logic [1:0]          o_error_code;
    logic                o_last;

    token_scoreboard sb = new();

    int         tx_idle_pct  = 0;
    int         rx_stall_pct = 0;
    int         hold_ticket  = 0;
    int         hold_seen    = 0;
    int         hold_left    = 0;
    int         cycles       = 0;
    logic [7:0] script[$];
    logic [7:0] prev_byte    = CH_LF;

    source_tokenizer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_kind  (o_result_kind),
        .o_value_char   (o_value_char),
        .o_token_length (o_token_length),
        .o_line         (o_line),
        .o_column       (o_column),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Receiver: check accepted results, stall at random, hold off on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_result_kind, o_value_char, o_token_length, o_line, o_column,
                            o_error_code, o_last);
        end
        if (hold_seen != hold_ticket) begin
            hold_seen = hold_ticket;
            hold_left = PRESSURE_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function automatic void put(input logic [7:0] b);
        script.insert(script.size(), b);
        prev_byte = b;
    endfunction

    function automatic logic [7:0] rand_letter();
        int n;
        n = $urandom_range(0, 51);
        return (n < 26) ? 8'h61 + 8'(n) : 8'h41 + 8'(n - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_word_tail();
        int n;
        n = $urandom_range(0, 9);
        if (n < 5) begin
            return rand_letter();
        end else if (n < 9) begin
            return rand_digit();
        end
        return CH_UNDER;
    endfunction

    // Append one well-formed fragment; return how many of its bytes count as text (none for a comment)
    function automatic int add_fragment();
        int         pick;
        int         base;
        logic [7:0] b;
        logic [7:0] puncts[8];
        logic [7:0] blanks[4];
        puncts = '{CH_EQ, CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_STAR, CH_COLON};
        blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        base = script.size();
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            put(rand_letter());
            repeat ($urandom_range(0, 8)) put(rand_word_tail());
        end else if (pick < 37) begin
            repeat ($urandom_range(1, 6)) put(rand_digit());
        end else if (pick < 47) begin
            // keep a float from gluing onto a word or another number
            if (token_scoreboard::is_letter(prev_byte) || token_scoreboard::is_digit(prev_byte)
                    || prev_byte == CH_UNDER || prev_byte == CH_DOT) begin
                put(CH_SPACE);
            end
            repeat ($urandom_range(1, 4)) put(rand_digit());
            put(CH_DOT);
            repeat ($urandom_range(0, 4)) put(rand_digit());
        end else if (pick < 67) begin
            put(puncts[$urandom_range(0, 7)]);
        end else if (pick < 75) begin
            put(CH_DASH);
            put(CH_GT);
        end else if (pick < 95) begin
            put(blanks[$urandom_range(0, 3)]);
        end else begin
            // comment body carries arbitrary bytes, LF excepted
            put(CH_SLASH);
            put(CH_SLASH);
            repeat ($urandom_range(0, 12)) begin
                b = 8'($urandom_range(0, 255));
                put((b == CH_LF) ? CH_SPACE : b);
            end
            put(CH_LF);
            return 0;
        end
        return script.size() - base;
    endfunction

    // Offer one item, idling first at random, and note it once accepted
    task automatic send_item(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(b, eot);
    endtask

    task automatic send_script();
        while (script.size() > 0) begin
            send_item(script.pop_front(), 1'b0);
        end
    endtask

    // Drop valid and wait until every expected result is in and the pipe is empty
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] line_val, input logic [15:0] col_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START_LINE;
        i_cfg_data  <= line_val;
        @(posedge i_clk);
        sb.set_start(CFG_START_LINE, line_val);
        i_cfg_index <= CFG_START_COLUMN;
        i_cfg_data  <= col_val;
        @(posedge i_clk);
        sb.set_start(CFG_START_COLUMN, col_val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        string      opening;
        int         count;
        int         ending;
        logic [7:0] bad;

        // Hold reset, then release
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sweep the start registers; the last write sets the first byte's position,
        // near the top of both ranges so the first line's column saturates early
        // and the line saturates later on
        write_regs(16'hFFFF, 16'hFFFF);
        write_regs(16'h0000, 16'h0000);
        write_regs(16'hFFFF - 16'($urandom_range(10, 40)),
                   16'hFFFF - 16'($urandom_range(4, 16)));

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 60;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 60;
                end
                default: begin
                    tx_idle_pct  = 15;
                    rx_stall_pct = 15;
                end
            endcase

            if (ph == 0) begin
                // Directed opening: every token class, punctuation, arrow, comment with
                // high and NUL bytes
                opening = "aZ_9=12.05;(){}*:->0//";
                for (int i = 0; i < opening.len(); i++) begin
                    put(opening[i]);
                end
                put(8'hFF);
                put(8'h00);
                put(CH_LF);
                send_script();
                // Stall the receiver for a long stretch while items keep coming
                hold_ticket <= hold_ticket + 1;
            end else begin
                // Rewrite registers mid-text; they must not move the position
                drain();
                case (ph)
                    1:       write_regs(16'h0000, 16'hFFFF);
                    2:       write_regs(16'hFFFF, 16'h0000);
                    default: write_regs(16'($urandom), 16'($urandom));
                endcase
            end

            count = 0;
            while (count < RANDOM_PER_PHASE) begin
                count += add_fragment();
            end
            send_script();
        end

        // Close the text one way, then show what follows is ignored or repeated
        put(CH_SPACE);
        ending = $urandom_range(0, 6);
        case (ending)
            0: put(CH_SEMI);
            1: begin
                case ($urandom_range(0, 2))
                    0: put(rand_letter());
                    1: put(rand_digit());
                    default: begin
                        put(rand_digit());
                        put(CH_DOT);
                    end
                endcase
            end
            2: begin
                put(CH_DASH);
                put(rand_letter());
            end
            3: put(CH_DASH);
            4: begin
                put(CH_SLASH);
                put(rand_letter());
            end
            5: put(CH_SLASH);
            default: begin
                case ($urandom_range(0, 4))
                    0:       bad = CH_DOT;
                    1:       bad = CH_UNDER;
                    2:       bad = CH_GT;
                    3:       bad = 8'h00;
                    default: bad = 8'h80 + 8'($urandom_range(0, 127));
                endcase
                put(bad);
            end
        endcase
        send_script();
        send_item(8'($urandom), 1'b1);
        send_item(8'($urandom), 1'b0);
        send_item(8'($urandom), 1'b1);
        send_item(8'($urandom), 1'b0);

        drain();
        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/srctok_pkg.sv
design/srctok_front.sv
design/srctok_fifo.sv
design/srctok_back.sv
design/source_tokenizer.sv
bench/tok_check_pkg.sv
bench/tb_top.sv
